>>> src/rfp_pkg.sv
// Shared types and constants for the receive frame parser.
package rfp_pkg;

	// Parser phase; the one encoding above PH_TRAILER, 3'd7, is never entered.
	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_TYPE    = 3'd2,
		PH_ID      = 3'd3,
		PH_HDR     = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_TRAILER = 3'd6
	} rfp_phase_t;

	// Result event codes.
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PAYLOAD  = 3'd1,
		EV_COMMIT   = 3'd2,
		EV_TOO_LONG = 3'd3,
		EV_FULL     = 3'd4
	} rfp_event_t;

	localparam logic [7:0] PREAMBLE_0 = 8'hAA;
	localparam logic [7:0] PREAMBLE_1 = 8'h55;

	// Header byte positions that carry the big-endian length, and trailer size.
	localparam int HDR_LEN_HI    = 3;
	localparam int HDR_LEN_LO    = 4;
	localparam int TRAILER_BYTES = 8;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 32;

endpackage

>>> src/rx_frame_parser_unit.sv
// Byte-serial receive frame parser: preamble hunt, header decode, payload stream.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | into unit | in_valid / in_stall   | rx_byte
//   out     | from unit | out_valid / out_stall | event_res, payload_byte, payload_index,
//           |           |                      | frame_type, frame_length,
//           |           |                      | frames_received, frames_dropped
//
// Every accepted beat produces exactly one result beat, in the cycle after it is accepted.
// The parser state updates at the accepting edge; the result lands in a single
// output register, so a new byte is taken every cycle while that register is
// empty or is being drained in the same cycle.
// in_stall rises only when a result is held and the downstream stalls it.
// arst_n clears the phase, the counters and the output valid flag.
module rx_frame_parser_unit #(
	parameter int BUF_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic [11:0] payload_index,
	output logic [7:0]  frame_type,
	output logic [15:0] frame_length,
	output logic [31:0] frames_received,
	output logic [31:0] frames_dropped
);
	import rfp_pkg::*;

	// Byte total and field count never exceed BUF_BYTES.
	localparam int FC_W = $clog2(BUF_BYTES + 1);
	localparam logic [FC_W-1:0]  BUF_LIMIT = FC_W'(BUF_BYTES);
	localparam logic [LEN_W-1:0] BUF_LEN   = LEN_W'(BUF_BYTES);

	// Parser state.
	rfp_phase_t         phase_q, phase_d, phase_cur;
	logic [FC_W-1:0]    fc_q, fc_d, fc_inc;
	logic [FC_W-1:0]    bt_q, bt_d;
	logic [LEN_W-1:0]   len_q, len_d, len_hdr;
	logic [BYTE_W-1:0]  type_q, type_d;
	logic [BYTE_W-1:0]  lid_q, lid_d, id_gap;
	logic [CNT_W-1:0]   rcv_q, rcv_d;
	logic [CNT_W-1:0]   drp_q, drp_d;

	// Result computed from the accepted byte.
	rfp_event_t         ev_d;
	logic [BYTE_W-1:0]  pbyte_d;
	logic [IDX_W-1:0]   pidx_d;

	// Output register.
	logic               out_valid_q;
	rfp_event_t         ev_q;
	logic [BYTE_W-1:0]  pbyte_q;
	logic [IDX_W-1:0]   pidx_q;
	logic [BYTE_W-1:0]  otype_q;
	logic [LEN_W-1:0]   olen_q;
	logic [CNT_W-1:0]   orcv_q;
	logic [CNT_W-1:0]   odrp_q;

	logic in_acc, out_acc;

	// Hold the input while a result waits and the sink stalls.
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;

	assign fc_inc  = fc_q + 1'b1;
	assign id_gap  = rx_byte - lid_q - 8'd1;
	assign len_hdr = {len_q[LEN_W-1:BYTE_W], rx_byte};

	// Next state and result for one byte.
	always_comb begin
		phase_cur = phase_q;
		phase_d   = phase_q;
		fc_d      = fc_q;
		bt_d      = bt_q;
		len_d     = len_q;
		type_d    = type_q;
		lid_d     = lid_q;
		rcv_d     = rcv_q;
		drp_d     = drp_q;
		ev_d      = EV_NONE;
		pbyte_d   = '0;
		pidx_d    = '0;

		// Abort an open frame that has filled the buffer, then reparse the byte
		// as a fresh hunt.
		if (phase_q != PH_SYNC1 && bt_q >= BUF_LIMIT) begin
			ev_d      = EV_FULL;
			bt_d      = '0;
			phase_cur = PH_SYNC1;
			phase_d   = PH_SYNC1;
		end

		unique case (phase_cur)
			PH_SYNC1: begin
				if (rx_byte == PREAMBLE_0) begin
					bt_d    = FC_W'(1);
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == PREAMBLE_1) begin
					fc_d    = '0;
					bt_d    = bt_q + 1'b1;
					phase_d = PH_TYPE;
				end else if (rx_byte != PREAMBLE_0) begin
					phase_d = PH_SYNC1;
				end
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				fc_d    = '0;
				bt_d    = bt_q + 1'b1;
				phase_d = PH_ID;
			end
			PH_ID: begin
				// Add the id gap, modulo 256, to the dropped count.
				drp_d   = drp_q + CNT_W'(id_gap);
				lid_d   = rx_byte;
				fc_d    = '0;
				bt_d    = bt_q + 1'b1;
				phase_d = PH_HDR;
			end
			PH_HDR: begin
				bt_d = bt_q + 1'b1;
				fc_d = fc_inc;
				if (fc_inc == FC_W'(HDR_LEN_HI)) begin
					len_d = {rx_byte, {BYTE_W{1'b0}}};
				end else if (fc_inc == FC_W'(HDR_LEN_LO)) begin
					len_d = len_hdr;
					fc_d  = '0;
					if (len_hdr > BUF_LEN) begin
						ev_d    = EV_TOO_LONG;
						phase_d = PH_SYNC1;
					end else if (len_hdr == '0) begin
						phase_d = PH_TRAILER;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				ev_d    = EV_PAYLOAD;
				pbyte_d = rx_byte;
				pidx_d  = IDX_W'(fc_q);
				bt_d    = bt_q + 1'b1;
				fc_d    = fc_inc;
				if (LEN_W'(fc_inc) == len_q) begin
					fc_d    = '0;
					phase_d = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				// Consume trailer bytes unchecked; the last one commits.
				bt_d = bt_q + 1'b1;
				fc_d = fc_inc;
				if (fc_inc == FC_W'(TRAILER_BYTES)) begin
					rcv_d   = rcv_q + 1'b1;
					ev_d    = EV_COMMIT;
					phase_d = PH_SYNC1;
				end
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
		end else if (in_acc) begin
			phase_q <= phase_d;
		end
	end

	// Frame counters and header fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			bt_q   <= '0;
			len_q  <= '0;
			type_q <= '0;
			lid_q  <= '0;
			rcv_q  <= '0;
			drp_q  <= '0;
		end else if (in_acc) begin
			fc_q   <= fc_d;
			bt_q   <= bt_d;
			len_q  <= len_d;
			type_q <= type_d;
			lid_q  <= lid_d;
			rcv_q  <= rcv_d;
			drp_q  <= drp_d;
		end
	end

	// Output valid: set on accept, drop once drained with nothing new behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; advances only with an accepted byte.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ev_q    <= ev_d;
			pbyte_q <= pbyte_d;
			pidx_q  <= pidx_d;
			otype_q <= type_d;
			olen_q  <= len_d;
			orcv_q  <= rcv_d;
			odrp_q  <= drp_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = ev_q;
	assign payload_byte    = pbyte_q;
	assign payload_index   = pidx_q;
	assign frame_type      = otype_q;
	assign frame_length    = olen_q;
	assign frames_received = orcv_q;
	assign frames_dropped  = odrp_q;

	// An accepted byte always leaves a result behind.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted byte left no result");

	// A payload byte inside an unfilled buffer is streamed out.
	a_payload_event: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && phase_q == PH_PAYLOAD && bt_q < BUF_LIMIT |=> ev_q == EV_PAYLOAD)
		else $error("payload byte not streamed");

	// While in the payload, the count stays below the frame length.
	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> LEN_W'(fc_q) < len_q)
		else $error("payload count ran past length");

	// The received count moves only with a commit.
	a_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && ev_d != EV_COMMIT |=> rcv_q == $past(rcv_q))
		else $error("received count changed without commit");

endmodule

>>> tb/rfp_tb_pkg.sv
`timescale 1ns / 1ps
// Result record, frame parser predictor and scoreboard for the frame parser bench.
package rfp_tb_pkg;
	import rfp_pkg::*;

	typedef struct packed {
		rfp_event_t  ev;
		logic [7:0]  pbyte;
		logic [11:0] pidx;
		logic [7:0]  ftype;
		logic [15:0] flen;
		logic [31:0] rcv;
		logic [31:0] drp;
	} parse_result_t;

	class frame_scoreboard;
		int            buf_sz;
		rfp_phase_t    phase;
		logic [12:0]   field_cnt;
		logic [12:0]   total;
		logic [15:0]   len_reg;
		logic [7:0]    type_reg;
		logic [7:0]    last_id;
		logic [31:0]   rcv_cnt;
		logic [31:0]   drop_cnt;
		parse_result_t exp_q[$];
		int            errors;
		int            ev_seen[5];

		function new(int buf_sz_i);
			buf_sz    = buf_sz_i;
			phase     = PH_SYNC1;
			field_cnt = '0;
			total     = '0;
			len_reg   = '0;
			type_reg  = '0;
			last_id   = '0;
			rcv_cnt   = '0;
			drop_cnt  = '0;
			errors    = 0;
			foreach (ev_seen[i]) ev_seen[i] = 0;
		endfunction

		function int pending();
			return exp_q.size();
		endfunction

		// Advance the parser by one accepted byte and queue the result it yields.
		function void note_byte(logic [7:0] b);
			parse_result_t r;
			logic [7:0]    gap;
			r    = '0;
			r.ev = EV_NONE;
			// An open frame that has filled the buffer is dropped before the byte is parsed.
			if (phase != PH_SYNC1 && 32'(total) >= buf_sz) begin
				r.ev  = EV_FULL;
				total = '0;
				phase = PH_SYNC1;
			end
			case (phase)
				PH_SYNC1: begin
					if (b == PREAMBLE_0) begin
						total = 13'd1;
						phase = PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (b == PREAMBLE_1) begin
						field_cnt = '0;
						total     = total + 13'd1;
						phase     = PH_TYPE;
					end else if (b != PREAMBLE_0) begin
						phase = PH_SYNC1;
					end
				end
				PH_TYPE: begin
					type_reg  = b;
					field_cnt = '0;
					total     = total + 13'd1;
					phase     = PH_ID;
				end
				PH_ID: begin
					gap       = b - last_id - 8'd1;
					drop_cnt  = drop_cnt + {24'd0, gap};
					last_id   = b;
					field_cnt = '0;
					total     = total + 13'd1;
					phase     = PH_HDR;
				end
				PH_HDR: begin
					total     = total + 13'd1;
					field_cnt = field_cnt + 13'd1;
					if (field_cnt == HDR_LEN_HI) begin
						len_reg = {b, 8'h00};
					end else if (field_cnt == HDR_LEN_LO) begin
						len_reg   = len_reg | {8'h00, b};
						field_cnt = '0;
						if (32'(len_reg) > buf_sz) begin
							r.ev  = EV_TOO_LONG;
							phase = PH_SYNC1;
						end else if (len_reg == '0) begin
							phase = PH_TRAILER;
						end else begin
							phase = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					r.ev      = EV_PAYLOAD;
					r.pbyte   = b;
					r.pidx    = field_cnt[11:0];
					total     = total + 13'd1;
					field_cnt = field_cnt + 13'd1;
					if ({3'b000, field_cnt} == len_reg) begin
						field_cnt = '0;
						phase     = PH_TRAILER;
					end
				end
				PH_TRAILER: begin
					total     = total + 13'd1;
					field_cnt = field_cnt + 13'd1;
					if (field_cnt == TRAILER_BYTES) begin
						rcv_cnt = rcv_cnt + 32'd1;
						r.ev    = EV_COMMIT;
						phase   = PH_SYNC1;
					end
				end
				default: phase = PH_SYNC1;
			endcase
			r.ftype = type_reg;
			r.flen  = len_reg;
			r.rcv   = rcv_cnt;
			r.drp   = drop_cnt;
			exp_q.push_back(r);
		endfunction

		function void cmp_field(string name, logic [31:0] want_v, logic [31:0] got_v);
			if (want_v !== got_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
				errors++;
			end
		endfunction

		// Match one accepted result beat against the oldest queued result.
		function void check_result(parse_result_t got);
			parse_result_t want;
			if (exp_q.size() == 0) begin
				$error("result beat with no byte pending: event_res 0x%0h", got.ev);
				errors++;
				return;
			end
			want = exp_q.pop_front();
			ev_seen[want.ev]++;
			cmp_field("event_res", want.ev, got.ev);
			cmp_field("payload_byte", want.pbyte, got.pbyte);
			cmp_field("payload_index", want.pidx, got.pidx);
			cmp_field("frame_type", want.ftype, got.ftype);
			cmp_field("frame_length", want.flen, got.flen);
			cmp_field("frames_received", want.rcv, got.rcv);
			cmp_field("frames_dropped", want.drp, got.drp);
		endfunction
	endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level bench for the receive frame parser: stimulus, handshake monitor and run control.
module tb_top;
	import rfp_pkg::*;
	import rfp_tb_pkg::*;

	localparam int BUF_BYTES    = 256;
	localparam int ITEM_TARGET  = 1500;
	localparam int RUN_LIMIT_NS = 4_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  payload_byte;
	logic [11:0] payload_index;
	logic [7:0]  frame_type;
	logic [15:0] frame_length;
	logic [31:0] frames_received;
	logic [31:0] frames_dropped;

	// Set while both sides must run without a single gap or stall.
	bit              no_gaps    = 1'b0;
	// Count of accepted input beats; bumped at the rising edge, read at the falling one.
	int              in_beats   = 0;
	int              bytes_sent = 0;
	frame_scoreboard sb;

	rx_frame_parser_unit #(
		.BUF_BYTES(BUF_BYTES)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_res      (event_res),
		.payload_byte   (payload_byte),
		.payload_index  (payload_index),
		.frame_type     (frame_type),
		.frame_length   (frame_length),
		.frames_received(frames_received),
		.frames_dropped (frames_dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Downstream: stall about 22 beats in a hundred, except in the quiet stretch.
	always @(negedge clk) begin
		out_stall <= !no_gaps && ($urandom_range(0, 99) < 22);
	end

	// Sample both handshakes at the rising edge. Feed every accepted byte to the
	// predictor first, then check the result beat, if any, that left this edge.
	always @(posedge clk) begin
		parse_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_byte(rx_byte);
				in_beats++;
			end
			if (out_valid && !out_stall) begin
				got.ev    = rfp_event_t'(event_res);
				got.pbyte = payload_byte;
				got.pidx  = payload_index;
				got.ftype = frame_type;
				got.flen  = frame_length;
				got.rcv   = frames_received;
				got.drp   = frames_dropped;
				sb.check_result(got);
			end
		end
	end

	// Drive one byte beat, maybe after a one-cycle gap, and hold it until accepted.
	// A gap comes ahead of about 28 bytes in a hundred. Returns at the falling edge after
	// the accepting edge, valid still high.
	task automatic drive_byte(input logic [7:0] b);
		int want;
		if (!no_gaps && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			@(negedge clk);
		end
		want = in_beats + 1;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(negedge clk); while (in_beats != want);
		bytes_sent++;
	endtask

	// Drop valid and hold off until every queued result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Send a frame: preamble, type, id, two filler bytes, length, payload, trailer.
	// A cut of zero or more truncates the frame to that many bytes. A length above
	// the buffer size gets only a few payload bytes, as the parser drops it anyway.
	task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fid,
			input logic [15:0] flen, input int cut, input bit aa_fill);
		logic [7:0] fb[$];
		int         npay;
		fb = {PREAMBLE_0, PREAMBLE_1, ftype, fid, 8'($urandom), 8'($urandom),
			flen[15:8], flen[7:0]};
		npay = (int'(flen) > BUF_BYTES) ? 4 : int'(flen);
		for (int i = 0; i < npay; i++) fb.push_back(aa_fill ? PREAMBLE_0 : 8'($urandom));
		for (int i = 0; i < TRAILER_BYTES; i++) fb.push_back(8'($urandom));
		if (cut >= 0 && cut < fb.size()) fb = fb[0:cut-1];
		foreach (fb[i]) drive_byte(fb[i]);
	endtask

	initial begin
		logic [7:0]  next_id;
		logic [7:0]  fid;
		logic [15:0] flen;
		int          frame_no;
		int          pick;
		int          sel;
		bit          mid_drain_done;

		sb             = new(BUF_BYTES);
		next_id        = 8'h00;
		frame_no       = 0;
		mid_drain_done = 1'b0;

		// Hold reset, then release it at a falling edge, away from the rising edge.
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: noise while hunting, including a lone 0x55.
		drive_byte(8'h00);
		drive_byte(8'hFF);
		drive_byte(PREAMBLE_1);
		// Repeated 0xAA ahead of the 0x55; zero-length frame goes straight to trailer.
		// Id 0x00 after reset is a full wrap gap of 255.
		drive_byte(PREAMBLE_0);
		drive_byte(PREAMBLE_0);
		send_frame(8'h00, 8'h00, 16'd0, -1, 1'b0);
		// One-byte payload, next id in sequence: no gap.
		send_frame(8'hFF, 8'h01, 16'd1, -1, 1'b0);
		// Largest length and the first length past the buffer: both rejected.
		send_frame(8'h5A, 8'h80, 16'hFFFF, 8, 1'b0);
		send_frame(8'hA5, 8'h81, 16'(BUF_BYTES + 1), 8, 1'b0);
		next_id = 8'h82;
		drain_results();

		// Random: mostly well-formed frames, plus truncated frames and line noise.
		while (bytes_sent < ITEM_TARGET) begin
			no_gaps = (bytes_sent >= 500 && bytes_sent < 750);
			if (!mid_drain_done && bytes_sent >= 1000) begin
				drain_results();
				mid_drain_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				frame_no++;
				sel = $urandom_range(0, 99);
				// Pin the buffer edges once each: last length that commits,
				// first that overflows in the trailer, and the full buffer.
				if (frame_no == 5) flen = 16'(BUF_BYTES - 16);
				else if (frame_no == 15) flen = 16'(BUF_BYTES - 15);
				else if (frame_no == 25) flen = 16'(BUF_BYTES);
				else if (sel < 2) flen = 16'($urandom_range(BUF_BYTES - 30, BUF_BYTES));
				else if (sel == 2) flen = 16'hFFFF;
				else if (sel < 7) flen = 16'($urandom_range(BUF_BYTES + 1, 65535));
				else if (sel < 17) flen = 16'd0;
				else flen = 16'($urandom_range(1, 24));
				fid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : next_id;
				send_frame(8'($urandom), fid, flen, -1, frame_no == 25);
				next_id = fid + 8'd1;
			end else if (pick < 85) begin
				flen = 16'($urandom_range(0, 24));
				send_frame(8'($urandom), next_id, flen,
					$urandom_range(1, 15 + int'(flen)), 1'b0);
				next_id = next_id + 8'd1;
			end else begin
				repeat ($urandom_range(1, 6)) begin
					sel = $urandom_range(0, 3);
					drive_byte(sel == 0 ? PREAMBLE_0 : sel == 1 ? PREAMBLE_1 : 8'($urandom));
				end
			end
		end
		no_gaps = 1'b0;

		// Wait out every result, then a short tail for any stray beat.
		drain_results();
		repeat (8) @(negedge clk);

		$display("covered %0d byte beats, %0d frames attempted; results seen:", bytes_sent,
			frame_no);
		$display("  %0d payload, %0d committed, %0d too long, %0d buffer full, %0d idle",
			sb.ev_seen[EV_PAYLOAD], sb.ev_seen[EV_COMMIT], sb.ev_seen[EV_TOO_LONG],
			sb.ev_seen[EV_FULL], sb.ev_seen[EV_NONE]);
		if (sb.errors == 0) begin
			$display("rx_frame_parser_unit regression: pass");
		end else begin
			$display("rx_frame_parser_unit regression: fail");
		end
		$finish;
	end

	// Hard stop for a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("rx_frame_parser_unit regression: fail");
		$finish;
	end

endmodule
